FILE: src/hex_record_line_parser_macros.svh
// Assertion macros used by the port-level checker of the capture-line parser.
// Depends on nothing; each macro expects clk (the first two also rst) at its use.
`ifndef HEX_RECORD_LINE_PARSER_MACROS_SVH
`define HEX_RECORD_LINE_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HRLP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hrlp same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HRLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrlp next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define HRLP_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hrlp reset check failed");

`endif

FILE: src/hrlp_pkg.sv
// Shared types, codes and helpers of the capture-line parser.
// Used by the interfaces, the front, queue and back modules and the checker.
`timescale 1ns / 1ps

package hrlp_pkg;

  localparam int MAX_RECORD_BYTES = 4096;
  localparam int CNT_W            = 13;
  localparam int QDEPTH           = 4;
  localparam int QAW              = $clog2(QDEPTH);

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_DOT   = 8'h2e;  // '.'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;

  typedef enum logic [3:0] {
    PH_LINE     = 4'd0,
    PH_COMMENT  = 4'd1,
    PH_SECS     = 4'd2,
    PH_FRAC     = 4'd3,
    PH_NIB1     = 4'd5,
    PH_NIB2     = 4'd6,
    PH_TRAIL    = 4'd7,
    PH_TCOMMENT = 4'd8,
    PH_SKIP     = 4'd9
  } phase_t;

  // Character class produced by the front; nib holds the digit or hex value.
  typedef struct packed {
    logic       is_digit;
    logic       is_hex;
    logic       is_ws;
    logic       is_nl;
    logic       is_hash;
    logic       is_dot;
    logic [3:0] nib;
  } cls_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       byte_value;
    logic [31:0]      seconds;
    logic [31:0]      fraction;
    logic [CNT_W-1:0] byte_count;
  } res_t;

  // acc * 10 + digit, held at all ones on overflow.
  function automatic logic [31:0] dec_sat(input logic [31:0] acc, input logic [3:0] digit);
    logic [35:0] wide;
    wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, digit};
    if (wide[35:32] != 4'd0) begin
      return 32'hffff_ffff;
    end
    return wide[31:0];
  endfunction

endpackage

FILE: src/hrlp_if.sv
// Valid/ready channel interfaces for the character input and the result output.
// Depends on hrlp_pkg for the field widths.
`timescale 1ns / 1ps

interface hrlp_char_if import hrlp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
  modport monitor (input valid, input char_code, input ready);
endinterface

interface hrlp_rec_if import hrlp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [7:0]       byte_value;
  logic [31:0]      seconds;
  logic [31:0]      fraction;
  logic [CNT_W-1:0] byte_count;

  modport source (output valid, output kind, output byte_value, output seconds,
                  output fraction, output byte_count, input ready);
  modport sink (input valid, input kind, input byte_value, input seconds,
                input fraction, input byte_count, output ready);
  modport monitor (input valid, input kind, input byte_value, input seconds,
                   input fraction, input byte_count, input ready);
endinterface

FILE: src/hrlp_front.sv
// Front end: takes character beats and classifies each one for the back end.
// Depends on hrlp_pkg and hrlp_char_if.
`timescale 1ns / 1ps

module hrlp_front import hrlp_pkg::*; (
  hrlp_char_if.sink in_ch,
  input  logic      q_full,
  output logic      q_push,
  output cls_t      q_item
);

  logic [7:0] c;
  logic       dig;
  logic       low_hex;
  logic       up_hex;

  assign c       = in_ch.char_code;
  assign dig     = (c >= CH_ZERO) && (c <= CH_NINE);
  assign low_hex = (c >= CH_LA) && (c <= CH_LF);
  assign up_hex  = (c >= CH_UA) && (c <= CH_UF);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_item.is_digit = dig;
    q_item.is_hex   = dig || low_hex || up_hex;
    q_item.is_ws    = (c == CH_SPACE) || (c == CH_TAB);
    q_item.is_nl    = (c == CH_NL);
    q_item.is_hash  = (c == CH_HASH);
    q_item.is_dot   = (c == CH_DOT);
    // Letters a-f and A-F share their low nibble pattern: 1..6 maps to 10..15.
    if (dig) begin
      q_item.nib = c[3:0];
    end else begin
      q_item.nib = c[3:0] + 4'd9;
    end
  end

endmodule

FILE: src/hrlp_queue.sv
// Short queue of classified characters between the front and the back end.
// Depends on hrlp_pkg.
`timescale 1ns / 1ps

module hrlp_queue import hrlp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t push_item,
  output logic full,
  input  logic pop,
  output logic valid,
  output cls_t head
);

  cls_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/hrlp_back.sv
// Back end: line-parsing state machine, timestamp accumulators and result register.
// Depends on hrlp_pkg and hrlp_rec_if.
`timescale 1ns / 1ps

module hrlp_back import hrlp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  cls_t      q_item,
  output logic      q_pop,
  hrlp_rec_if.source out_rec
);

  phase_t           phase, phase_next;
  logic [31:0]      secs, secs_next;
  logic [31:0]      frac, frac_next;
  logic [3:0]       high_nib, high_nib_next;
  logic [CNT_W-1:0] count, count_next;
  logic             res_valid;
  res_t             res;
  logic             out_valid;
  res_t             out_data;
  logic [31:0]      secs_dec;
  logic [31:0]      frac_dec;

  assign q_pop    = q_valid && (!out_valid || out_rec.ready);
  assign secs_dec = dec_sat(secs, q_item.nib);
  assign frac_dec = dec_sat(frac, q_item.nib);

  always_comb begin
    phase_next    = phase;
    secs_next     = secs;
    frac_next     = frac;
    high_nib_next = high_nib;
    count_next    = count;
    res_valid     = 1'b0;
    res           = '0;
    res.kind      = KIND_ABORT;
    // Below, done reports the record and returns to PH_LINE; done or abort clears it.
    case (phase)
      PH_LINE: begin
        if (q_item.is_digit) begin
          secs_next     = {28'd0, q_item.nib};
          frac_next     = '0;
          high_nib_next = '0;
          count_next    = '0;
          phase_next    = PH_SECS;
        end else if (q_item.is_hash) begin
          phase_next = PH_COMMENT;
        end else if (!q_item.is_ws && !q_item.is_nl) begin
          res_valid  = 1'b1;
          phase_next = PH_SKIP;
        end
      end
      PH_COMMENT: begin
        if (q_item.is_nl) begin
          phase_next = PH_LINE;
        end
      end
      PH_SECS: begin
        if (q_item.is_digit) begin
          secs_next = secs_dec;
        end else if (q_item.is_dot) begin
          frac_next  = '0;
          phase_next = PH_FRAC;
        end else begin
          res_valid  = 1'b1;
          phase_next = q_item.is_nl ? PH_LINE : PH_SKIP;
        end
      end
      PH_FRAC: begin
        if (q_item.is_digit) begin
          frac_next = frac_dec;
        end else if (q_item.is_ws) begin
          phase_next = PH_NIB1;
        end else begin
          res_valid  = 1'b1;
          phase_next = q_item.is_nl ? PH_LINE : PH_SKIP;
        end
      end
      PH_NIB1: begin
        if (q_item.is_hex) begin
          high_nib_next = q_item.nib;
          phase_next    = PH_NIB2;
        end else if (q_item.is_ws) begin
          phase_next = PH_TRAIL;
        end else if (q_item.is_nl) begin
          res_valid = 1'b1;
          res.kind  = KIND_DONE;
        end else begin
          res_valid  = 1'b1;
          phase_next = PH_SKIP;
        end
      end
      PH_NIB2: begin
        if (q_item.is_hex && (count < CNT_W'(MAX_RECORD_BYTES))) begin
          res_valid      = 1'b1;
          res.kind       = KIND_BYTE;
          res.byte_value = {high_nib, q_item.nib};
          count_next     = count + 1'b1;
          phase_next     = PH_NIB1;
        end else begin
          // A full buffer, a newline after half a byte or a bad character.
          res_valid  = 1'b1;
          phase_next = (q_item.is_nl && !q_item.is_hex) ? PH_LINE : PH_SKIP;
        end
      end
      PH_TRAIL: begin
        if (q_item.is_hash) begin
          phase_next = PH_TCOMMENT;
        end else if (q_item.is_nl) begin
          res_valid = 1'b1;
          res.kind  = KIND_DONE;
        end else if (!q_item.is_ws) begin
          res_valid  = 1'b1;
          phase_next = PH_SKIP;
        end
      end
      PH_TCOMMENT: begin
        if (q_item.is_nl) begin
          res_valid = 1'b1;
          res.kind  = KIND_DONE;
        end
      end
      default: begin
        if (q_item.is_nl) begin
          phase_next = PH_LINE;
        end
      end
    endcase
    if (res_valid && (res.kind == KIND_DONE)) begin
      res.seconds    = secs;
      res.fraction   = frac;
      res.byte_count = count;
      phase_next     = PH_LINE;
    end
    if (res_valid && (res.kind != KIND_BYTE)) begin
      secs_next     = '0;
      frac_next     = '0;
      high_nib_next = '0;
      count_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LINE;
      secs     <= '0;
      frac     <= '0;
      high_nib <= '0;
      count    <= '0;
    end else if (q_pop) begin
      phase    <= phase_next;
      secs     <= secs_next;
      frac     <= frac_next;
      high_nib <= high_nib_next;
      count    <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_rec.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      out_data <= res;
    end
  end

  assign out_rec.valid      = out_valid;
  assign out_rec.kind       = out_data.kind;
  assign out_rec.byte_value = out_data.byte_value;
  assign out_rec.seconds    = out_data.seconds;
  assign out_rec.fraction   = out_data.fraction;
  assign out_rec.byte_count = out_data.byte_count;

endmodule

FILE: src/hex_record_line_parser.sv
// Capture-line parser: one ASCII character per input beat; emits payload bytes,
// record-complete and record-abort beats. Each character is classified on entry,
// waits in a four-entry queue and is consumed by the parsing state machine, one
// character per cycle while no result waits at the output, so a steady stream of
// one beat per clock is then sustained; the state machine's registered update of
// phase and the saturating times-ten accumulators sets that rate. A result
// appears in the cycle after its character is taken and is held in an output
// register, so the input keeps flowing while a result waits until the queue fills.
`timescale 1ns / 1ps

module hex_record_line_parser import hrlp_pkg::*; (
  input logic        clk,
  input logic        rst,
  hrlp_char_if.sink  in_ch,
  hrlp_rec_if.source out_rec
);

  logic q_full;
  logic q_push;
  cls_t q_in;
  logic q_pop;
  logic q_valid;
  cls_t q_head;

  hrlp_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  hrlp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  hrlp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_head),
    .q_pop   (q_pop),
    .out_rec (out_rec)
  );

endmodule

FILE: src/hrlp_checker.sv
// Port-level checks of the capture-line parser, bound to the top level.
// Depends on hrlp_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "hex_record_line_parser_macros.svh"

module hrlp_checker import hrlp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             valid,
  input logic             ready,
  input logic [1:0]       kind,
  input logic [7:0]       byte_value,
  input logic [31:0]      seconds,
  input logic [31:0]      fraction,
  input logic [CNT_W-1:0] byte_count
);

  logic stalled;
  logic is_byte;
  logic is_abort;
  logic is_done;
  logic byte_clean;
  logic abort_clean;
  logic done_clean;
  res_t beat;

  assign stalled     = valid && !ready;
  assign is_byte     = valid && (kind == KIND_BYTE);
  assign is_abort    = valid && (kind == KIND_ABORT);
  assign is_done     = valid && (kind == KIND_DONE);
  assign byte_clean  = (seconds == 32'd0) && (fraction == 32'd0) && (byte_count == '0);
  assign abort_clean = (byte_value == 8'd0) && (seconds == 32'd0) && (byte_count == '0);
  assign done_clean  = (byte_count <= CNT_W'(MAX_RECORD_BYTES)) && (byte_value == 8'd0);
  assign beat        = {kind, byte_value, seconds, fraction, byte_count};

  // A beat that is not taken stays, with the same payload.
  `HRLP_ASSERT_NEXT(a_hold, stalled, valid && $stable(beat))
  `HRLP_ASSERT_NOW(a_byte_clean, is_byte, byte_clean)
  `HRLP_ASSERT_NOW(a_abort_clean, is_abort, abort_clean)
  `HRLP_ASSERT_NOW(a_done_count, is_done, done_clean)
  `HRLP_ASSERT_RST(a_reset_idle, rst, !valid)

endmodule

bind hex_record_line_parser hrlp_checker u_hrlp_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (out_rec.valid),
  .ready      (out_rec.ready),
  .kind       (out_rec.kind),
  .byte_value (out_rec.byte_value),
  .seconds    (out_rec.seconds),
  .fraction   (out_rec.fraction),
  .byte_count (out_rec.byte_count)
);
